// ===== hdl/ljcd_pkg.sv =====
// ---------------------------------------------------------------------------
// ljcd_pkg
// Shared types and constants for the LAN join code decoder.
// ---------------------------------------------------------------------------
package ljcd_pkg;

    // Character codes recognised in a join code
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Configuration register indexes
    localparam logic [1:0] REG_JOINER_ADDRESS = 2'd0;
    localparam logic [1:0] REG_LOCAL_NETMASK  = 2'd1;
    localparam logic [1:0] REG_DEFAULT_PORT   = 2'd2;

    // Limits
    localparam logic [3:0] MAX_ADDR_DIGITS = 4'd9;
    localparam logic [2:0] MAX_PORT_DIGITS = 3'd5;

    // Register reset values
    localparam logic [31:0] JOINER_ADDRESS_RST = 32'h0000_0000;
    localparam logic [31:0] LOCAL_NETMASK_RST  = 32'hFFFF_FF00;
    localparam logic [15:0] DEFAULT_PORT_RST   = 16'h0000;

    // Decode state captured on the last character of a code
    typedef struct packed {
        logic        err;
        logic [3:0]  oct_cnt;
        logic [31:0] tail;
        logic [16:0] port_acc;
        logic [2:0]  port_cnt;
    } ljcd_final_t;

endpackage

// ===== hdl/lan_join_code_decoder_core.sv =====
// ---------------------------------------------------------------------------
// lan_join_code_decoder_core
// Decodes a streamed LAN join code into a peer IPv4 address and port.
// ---------------------------------------------------------------------------
// Usage
//   s_ channel: one ASCII character per request in s_tdata, s_tlast marks the
//   final character of a code. Spaces are skipped; digits before the first
//   dash form the trailing address octets (three digits each), digits after
//   it form the port.
//   m_ channel: exactly one result per code, issued for the request that
//   carries s_tlast. m_tuser carries the accepted flag; m_tdata carries the
//   address and port, both zero when the code is rejected.
//   cfg_ port: plain register writes (joiner address, netmask, default port),
//   read when a completed code moves into the result register; write only
//   while the block is idle.
// Timing
//   One character per cycle while s_tready is high. A code's final decode
//   state is captured in the capture stage, then merged with the joiner
//   address and checked on its way into the result register (m_tvalid).
// Reset / stall
//   aresetn (synchronous, active low) clears the decode state, the pipeline
//   and the registers to their defaults. When m_tready is held low, one more
//   completed code can wait in the capture stage; after that s_tready drops.
// ---------------------------------------------------------------------------
module lan_join_code_decoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] code_char
    input  logic        s_tlast,     // last_char
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,     // [31:0] peer_address, [47:32] peer_port
    output logic        m_tuser,     // [0] accepted
    // configuration
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    // ---------------------------------------------------------------- config
    logic [31:0] joiner_reg;
    logic [31:0] netmask_reg;
    logic [15:0] def_port_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            joiner_reg   <= ljcd_pkg::JOINER_ADDRESS_RST;
            netmask_reg  <= ljcd_pkg::LOCAL_NETMASK_RST;
            def_port_reg <= ljcd_pkg::DEFAULT_PORT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ljcd_pkg::REG_JOINER_ADDRESS: joiner_reg   <= cfg_wdata;
                ljcd_pkg::REG_LOCAL_NETMASK:  netmask_reg  <= cfg_wdata;
                ljcd_pkg::REG_DEFAULT_PORT:   def_port_reg <= cfg_wdata[15:0];
                default: ; // unknown index ignored
            endcase
        end
    end

    // ----------------------------------------------------------- handshakes
    logic        m_tvalid_reg;
    logic        snap_valid_reg;
    logic        out_free;
    logic        s_accept;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = !snap_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    // --------------------------------------------------- per-character decode
    logic        in_port_reg;
    logic [3:0]  oct_cnt_reg;
    logic [9:0]  partial_reg;
    logic [31:0] tail_reg;
    logic [16:0] port_acc_reg;
    logic [2:0]  port_cnt_reg;
    logic        err_reg;

    logic        in_port_next;
    logic [3:0]  oct_cnt_next;
    logic [9:0]  partial_next;
    logic [31:0] tail_next;
    logic [16:0] port_acc_next;
    logic [2:0]  port_cnt_next;
    logic        err_next;

    logic        is_digit;
    logic [3:0]  digit;
    logic [9:0]  partial_acc;
    logic [16:0] port_step;

    assign is_digit = (s_tdata >= ljcd_pkg::CHAR_ZERO) && (s_tdata <= ljcd_pkg::CHAR_NINE);
    assign digit    = 4'(s_tdata - ljcd_pkg::CHAR_ZERO);
    // three digits at most before the octet closes, so 10 bits never wrap
    assign partial_acc = 10'(14'(partial_reg) * 14'd10 + 14'(digit));
    assign port_step   = 17'(21'(port_acc_reg) * 21'd10 + 21'(digit));

    always_comb begin
        in_port_next  = in_port_reg;
        oct_cnt_next  = oct_cnt_reg;
        partial_next  = partial_reg;
        tail_next     = tail_reg;
        port_acc_next = port_acc_reg;
        port_cnt_next = port_cnt_reg;
        err_next      = err_reg;

        if (s_tdata == ljcd_pkg::CHAR_SPACE) begin
            // skipped
        end else if (!in_port_reg) begin
            if (s_tdata == ljcd_pkg::CHAR_DASH) begin
                in_port_next = 1'b1;
            end else if (!is_digit || oct_cnt_reg >= ljcd_pkg::MAX_ADDR_DIGITS) begin
                err_next = 1'b1;
            end else begin
                oct_cnt_next = oct_cnt_reg + 4'd1;
                partial_next = partial_acc;
                // octet closes on every third digit
                if (oct_cnt_next == 4'd3 || oct_cnt_next == 4'd6 || oct_cnt_next == 4'd9) begin
                    if (partial_acc > 10'd255) begin
                        err_next = 1'b1;
                    end
                    tail_next    = {tail_reg[23:0], partial_acc[7:0]};
                    partial_next = '0;
                end
            end
        end else begin
            if (!is_digit || port_cnt_reg >= ljcd_pkg::MAX_PORT_DIGITS) begin
                err_next = 1'b1;
            end else begin
                port_acc_next = port_step;
                port_cnt_next = port_cnt_reg + 3'd1;
            end
        end
    end

    // decode state: cleared on reset and after each last character
    always_ff @(posedge aclk) begin
        if (!aresetn || (s_accept && s_tlast)) begin
            in_port_reg  <= 1'b0;
            oct_cnt_reg  <= '0;
            partial_reg  <= '0;
            tail_reg     <= '0;
            port_acc_reg <= '0;
            port_cnt_reg <= '0;
            err_reg      <= 1'b0;
        end else if (s_accept) begin
            in_port_reg  <= in_port_next;
            oct_cnt_reg  <= oct_cnt_next;
            partial_reg  <= partial_next;
            tail_reg     <= tail_next;
            port_acc_reg <= port_acc_next;
            port_cnt_reg <= port_cnt_next;
            err_reg      <= err_next;
        end
    end

    // ------------------------------------------------------- capture stage
    ljcd_pkg::ljcd_final_t snap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
        end else if (s_accept && s_tlast) begin
            snap_valid_reg <= 1'b1;
        end else if (out_free) begin
            snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && s_tlast) begin
            snap_reg.err      <= err_next;
            snap_reg.oct_cnt  <= oct_cnt_next;
            snap_reg.tail     <= tail_next;
            snap_reg.port_acc <= port_acc_next;
            snap_reg.port_cnt <= port_cnt_next;
        end
    end

    // ---------------------------------------------------------- evaluation
    logic [1:0]  n_oct;       // octets given by the code
    logic [1:0]  need_oct;    // octets the netmask's host part requires
    logic [31:0] keep_mask;
    logic [31:0] host_field;
    logic [31:0] addr;
    logic [31:0] host_bits;
    logic [15:0] port_sel;
    logic        ok_addr;
    logic        ok_port;
    logic        ok;

    always_comb begin
        unique case (snap_reg.oct_cnt)
            4'd3:    begin n_oct = 2'd1; keep_mask = 32'hFFFF_FF00; end
            4'd6:    begin n_oct = 2'd2; keep_mask = 32'hFFFF_0000; end
            4'd9:    begin n_oct = 2'd3; keep_mask = 32'hFF00_0000; end
            default: begin n_oct = 2'd0; keep_mask = 32'hFFFF_FFFF; end
        endcase
    end

    // prefix length bands: >=24, 16..23, 8..15, below 8
    always_comb begin
        if (&netmask_reg[31:8]) begin
            need_oct = 2'd1;
        end else if (&netmask_reg[31:16]) begin
            need_oct = 2'd2;
        end else if (&netmask_reg[31:24]) begin
            need_oct = 2'd3;
        end else begin
            need_oct = 2'd0;
        end
    end

    assign host_field = ~keep_mask;
    assign addr       = (joiner_reg & keep_mask) | snap_reg.tail;
    assign host_bits  = addr & host_field;

    // n_oct of zero covers both no digits and a partial octet
    assign ok_addr = !snap_reg.err && (n_oct != 2'd0) && (n_oct >= need_oct)
                     && (host_bits != 32'd0) && (host_bits != host_field);

    always_comb begin
        if (snap_reg.port_cnt == 3'd0) begin
            port_sel = def_port_reg;
            ok_port  = (def_port_reg != 16'd0);
        end else begin
            port_sel = snap_reg.port_acc[15:0];
            ok_port  = (snap_reg.port_acc != 17'd0) && !snap_reg.port_acc[16];
        end
    end

    assign ok = ok_addr && ok_port;

    // ------------------------------------------------------ result register
    logic [47:0] m_tdata_reg;
    logic        m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= snap_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && snap_valid_reg) begin
            m_tuser_reg <= ok;
            m_tdata_reg <= ok ? {port_sel, addr} : 48'd0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== hdl/ljcd_checker.sv =====
// ---------------------------------------------------------------------------
// ljcd_checker
// Port-level checks for the join code decoder, bound to the top level.
// ---------------------------------------------------------------------------
module ljcd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // rejected codes carry an all-zero payload
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 48'd0)
        else $error("rejected result with non-zero payload");

    // an accepted endpoint never has port zero
    a_port_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[47:32] != 16'd0)
        else $error("accepted result with port zero");

    // a rising m_tvalid follows an accepted last character through the capture and result registers
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
        else $error("result without a completed code");

endmodule

bind lan_join_code_decoder_core ljcd_checker u_ljcd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== dv/ljcd_endpoint_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ljcd_endpoint_checker
// Watches the code and result streams of the join code decoder, works out
// the endpoint each completed code should give and compares it with the
// result that leaves the block.
// ---------------------------------------------------------------------------
module ljcd_endpoint_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] code_char
    input  logic        s_tlast,     // last_char
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,     // [31:0] peer_address, [47:32] peer_port
    input  logic        m_tuser,     // [0] accepted
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    output int          fail_count,
    output int          pending_results
);

    typedef struct packed {
        logic        accepted;
        logic [31:0] peer_address;
        logic [15:0] peer_port;
    } endpoint_t;

    // register copies
    logic [31:0] joiner_reg;
    logic [31:0] netmask_reg;
    logic [15:0] defport_reg;

    // decode state of the code in progress
    logic        in_port;
    logic [3:0]  oct_digits;
    logic [9:0]  oct_partial;
    logic [31:0] addr_tail;
    logic [16:0] port_value;
    logic [2:0]  port_digits;
    logic        code_bad;

    endpoint_t expected_endpoints[$];

    initial fail_count = 0;
    initial pending_results = 0;

    task automatic flag_error(input string note);
        $display("[%0t] mismatch: %s", $time, note);
        fail_count++;
    endtask

    function automatic void clear_code();
        in_port     = 1'b0;
        oct_digits  = '0;
        oct_partial = '0;
        addr_tail   = '0;
        port_value  = '0;
        port_digits = '0;
        code_bad    = 1'b0;
    endfunction

    function automatic void absorb_char(input logic [7:0] ch);
        logic       is_digit;
        logic [3:0] d;
        is_digit = (ch >= ljcd_pkg::CHAR_ZERO) && (ch <= ljcd_pkg::CHAR_NINE);
        d = is_digit ? 4'(ch - ljcd_pkg::CHAR_ZERO) : 4'd0;
        if (ch == ljcd_pkg::CHAR_SPACE)
            return;
        if (!in_port) begin
            if (ch == ljcd_pkg::CHAR_DASH) begin
                in_port = 1'b1;
            end else if (!is_digit || oct_digits >= ljcd_pkg::MAX_ADDR_DIGITS) begin
                code_bad = 1'b1;
            end else begin
                oct_partial = 10'(oct_partial * 10 + d);
                oct_digits  = oct_digits + 4'd1;
                if (oct_digits % 3 == 0) begin
                    if (oct_partial > 10'd255)
                        code_bad = 1'b1;
                    addr_tail   = {addr_tail[23:0], oct_partial[7:0]};
                    oct_partial = '0;
                end
            end
        end else begin
            if (!is_digit || port_digits >= ljcd_pkg::MAX_PORT_DIGITS) begin
                code_bad = 1'b1;
            end else begin
                port_value  = 17'(port_value * 10 + d);
                port_digits = port_digits + 3'd1;
            end
        end
    endfunction

    function automatic endpoint_t close_code();
        endpoint_t   r;
        logic        ok;
        int          n;
        int          prefix;
        int          need;
        logic [31:0] keep;
        logic [31:0] host;
        logic [31:0] addr;
        logic [16:0] port;
        ok = !code_bad;
        n  = oct_digits / 3;
        if (oct_digits == 0 || oct_digits % 3 != 0)
            ok = 1'b0;
        // leading ones of the mask decide how many octets the code must carry
        prefix = 0;
        while (prefix < 32 && netmask_reg[31 - prefix])
            prefix++;
        need = (prefix >= 24) ? 1 : (prefix >= 16) ? 2 : (prefix >= 8) ? 3 : 0;
        if (ok && n < need)
            ok = 1'b0;
        addr = '0;
        port = '0;
        if (ok) begin
            keep = 32'hFFFF_FFFF << (8 * n);
            host = ~keep;
            addr = (joiner_reg & keep) | addr_tail;
            if ((addr & host) == 32'd0 || (addr & host) == host)
                ok = 1'b0;
        end
        if (ok) begin
            if (port_digits == 0) begin
                if (defport_reg == 16'd0)
                    ok = 1'b0;
                port = {1'b0, defport_reg};
            end else begin
                if (port_value == 17'd0 || port_value > 17'd65535)
                    ok = 1'b0;
                port = port_value;
            end
        end
        r.accepted     = ok;
        r.peer_address = ok ? addr : 32'd0;
        r.peer_port    = ok ? port[15:0] : 16'd0;
        return r;
    endfunction

    always @(posedge aclk) begin
        endpoint_t got;
        endpoint_t want;
        if (!aresetn) begin
            joiner_reg  = ljcd_pkg::JOINER_ADDRESS_RST;
            netmask_reg = ljcd_pkg::LOCAL_NETMASK_RST;
            defport_reg = ljcd_pkg::DEFAULT_PORT_RST;
            clear_code();
            expected_endpoints.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    ljcd_pkg::REG_JOINER_ADDRESS: joiner_reg  = cfg_wdata;
                    ljcd_pkg::REG_LOCAL_NETMASK:  netmask_reg = cfg_wdata;
                    ljcd_pkg::REG_DEFAULT_PORT:   defport_reg = cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.accepted     = m_tuser;
                got.peer_address = m_tdata[31:0];
                got.peer_port    = m_tdata[47:32];
                if (expected_endpoints.size() == 0) begin
                    flag_error($sformatf("unexpected result acc=%0b addr=%h port=%0d",
                                         got.accepted, got.peer_address, got.peer_port));
                end else begin
                    want = expected_endpoints.pop_front();
                    if (got.accepted !== want.accepted)
                        flag_error($sformatf("accepted %0b, want %0b",
                                             got.accepted, want.accepted));
                    if (got.peer_address !== want.peer_address)
                        flag_error($sformatf("peer_address %h, want %h",
                                             got.peer_address, want.peer_address));
                    if (got.peer_port !== want.peer_port)
                        flag_error($sformatf("peer_port %0d, want %0d",
                                             got.peer_port, want.peer_port));
                end
            end
            if (s_tvalid && s_tready) begin
                absorb_char(s_tdata);
                if (s_tlast) begin
                    expected_endpoints.insert(expected_endpoints.size(), close_code());
                    clear_code();
                end
            end
        end
        pending_results = expected_endpoints.size();
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Join code decoder regression: directed codes for most rejection rules,
// then phases of random codes under changing register settings, with random
// gaps on both streams, a long result back-pressure and idle drains.
// ---------------------------------------------------------------------------
module tb;

    // index with no register behind it; writes must be ignored
    localparam logic [1:0] REG_SPARE = 2'd3;

    localparam int RESET_CYCLES   = 6;
    localparam int LONG_HOLD      = 150;  // result side back-pressure, cycles
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000; // cycles with no request moving and no register write
    localparam int PHASE_CHARS    = 90;
    localparam int NUM_PHASES     = 6;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] code_char
    logic        s_tlast;     // last_char
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;     // [31:0] peer_address, [47:32] peer_port
    logic        m_tuser;     // [0] accepted
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;

    int fail_count;
    int pending_results;

    // stimulus control shared between the sender and receiver processes
    logic s_quiet;      // sender: no gaps
    logic m_quiet;      // receiver: no stalls
    logic long_hold;    // receiver: one long stall on its next result
    int   chars_sent;
    int   idle_cycles = 0;

    logic [7:0] code_bytes[$];

    always #5 aclk = ~aclk;

    lan_join_code_decoder_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    ljcd_endpoint_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // Watchdog: any request on either stream or a register write counts as
    // progress; a long run without one means the block has hung.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no request for %0d cycles", $time, idle_cycles);
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random stall before each result, none in quiet stretches,
    // and one long stall on request from the stimulus so the block fills up.
    initial begin
        int hold;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (long_hold) begin
                long_hold = 1'b0;
                hold = LONG_HOLD;
            end else begin
                hold = m_quiet ? 0 : $urandom_range(0, 17);
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // Append one byte to the code being built.
    task automatic add_byte(input logic [7:0] b);
        code_bytes.insert(code_bytes.size(), b);
    endtask

    // Push a decimal number with leading zeros; an odd space creeps in.
    task automatic push_number(input int unsigned value, input int digits);
        int unsigned p;
        for (int i = digits - 1; i >= 0; i--) begin
            if ($urandom_range(0, 15) == 0)
                add_byte(ljcd_pkg::CHAR_SPACE);
            p = 1;
            repeat (i) p = p * 10;
            add_byte(ljcd_pkg::CHAR_ZERO + 8'((value / p) % 10));
        end
    endtask

    // Send the queued code, tlast on its final character. Each request
    // gets its own gap; s_tvalid stays high across back-to-back requests.
    task automatic send_code();
        int gap;
        if (code_bytes.size() == 0)
            add_byte(ljcd_pkg::CHAR_SPACE);
        foreach (code_bytes[i]) begin
            gap = s_quiet ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= code_bytes[i];
            s_tlast  <= (i == code_bytes.size() - 1);
            do @(posedge aclk); while (!s_tready);
            @(negedge aclk);
            chars_sent++;
        end
        code_bytes.delete();
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            add_byte(txt[i]);
        send_code();
    endtask

    // Stop offering and wait until every predicted result has come out,
    // then let the pipeline settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Back-to-back writes of all three registers, optionally the spare index.
    task automatic set_config(input logic [31:0] joiner, input logic [31:0] mask,
                              input logic [31:0] port_word, input logic touch_spare);
        cfg_wr_en <= 1'b1;
        cfg_index <= ljcd_pkg::REG_JOINER_ADDRESS;
        cfg_wdata <= joiner;
        @(negedge aclk);
        cfg_index <= ljcd_pkg::REG_LOCAL_NETMASK;
        cfg_wdata <= mask;
        @(negedge aclk);
        cfg_index <= ljcd_pkg::REG_DEFAULT_PORT;
        cfg_wdata <= port_word;
        @(negedge aclk);
        if (touch_spare) begin
            cfg_index <= REG_SPARE;
            cfg_wdata <= $urandom;
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
        cfg_wdata <= $urandom;
        @(negedge aclk);
    endtask

    // Mostly well-formed codes (octets, optional dash and port) with random
    // content; the rest noise bytes, stray digits, overlong parts and the like.
    task automatic build_random_code();
        int          kind;
        int          n;
        int          k;
        int          sel;
        int unsigned val;
        int unsigned lim;
        kind = $urandom_range(0, 19);
        if (kind < 2) begin
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
            return;
        end
        case (kind)
            2:       n = 0;                     // no address digits
            3:       n = 4;                     // one octet too many
            default: n = $urandom_range(1, 3);
        endcase
        repeat (n) begin
            sel = $urandom_range(0, 15);
            if (sel == 0)      val = 0;
            else if (sel == 1) val = 255;
            else if (sel == 2) val = $urandom_range(256, 999);
            else               val = $urandom_range(0, 255);
            push_number(val, 3);
        end
        if (kind == 4)
            push_number($urandom_range(0, 99), $urandom_range(1, 2));
        sel = $urandom_range(0, 7);
        if (sel == 2) begin
            add_byte(ljcd_pkg::CHAR_DASH);
        end else if (sel > 2) begin
            add_byte(ljcd_pkg::CHAR_DASH);
            k = (kind == 6) ? 6 : $urandom_range(1, 5);
            lim = 1;
            repeat (k) lim = lim * 10;
            case ($urandom_range(0, 9))
                0:       val = 0;
                1:       val = 65535;
                2:       val = 65536;
                3:       val = 99999;
                default: val = $urandom_range(0, lim - 1);
            endcase
            push_number(val % lim, k);
        end
        if (kind == 5)
            add_byte(8'($urandom));  // stray trailing byte
        if ($urandom_range(0, 7) == 0)
            add_byte(ljcd_pkg::CHAR_SPACE);
    endtask

    initial begin
        int          phase_start;
        logic [31:0] joiner_set[NUM_PHASES];
        logic [31:0] mask_set[NUM_PHASES];
        logic [31:0] port_set[NUM_PHASES];

        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = '0;
        cfg_wdata  = '0;
        s_quiet    = 1'b0;
        m_quiet    = 1'b0;
        long_hold  = 1'b0;
        chars_sent = 0;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: /24 mask, joiner 0, no default port.
        send_text("005-1");        // accepted
        send_text("255-65535");    // host part all ones
        send_text("000-9");        // host part all zeros
        send_text("256-9");        // octet over 255
        send_text("12-9");         // digits not a multiple of three
        send_text("-9");           // no address digits
        send_text("010");          // no port and no default
        send_text("0 1 0-8 0");    // spaces skipped
        send_text("1a0-9");        // non-digit
        add_byte(8'hFF);
        add_byte(8'h00);
        send_code();               // bytes out of range

        // /32 mask, joiner all ones, default port at maximum.
        drain();
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_FFFF, 1'b1);
        send_text("010");          // default port
        send_text("010-");         // dash alone: default port
        send_text("010-0");        // port zero
        send_text("010-65536");    // port too big
        send_text("010--1");       // second dash
        send_text("0102030405-1"); // tenth address digit
        send_text("010-123456");   // sixth port digit

        // Random phases; the low half of the port word is all the register
        // keeps, so some writes carry junk above it.
        joiner_set = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hC0A8_0000 | $urandom_range(0, 65535),
                       $urandom, $urandom, $urandom};
        mask_set   = '{32'hFFFF_0000, 32'hFF00_0000, 32'hFFFF_FF00,
                       32'hFFFF_FFFF, 32'h0000_0000, $urandom};
        port_set   = '{32'h0000_1F90, 32'h0000_0000, 32'h0000_FFFF,
                       $urandom | 32'hFFFF_0000, 32'h0000_0001, $urandom};

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            set_config(joiner_set[ph], mask_set[ph], port_set[ph], 1'b0);
            s_quiet = (ph == 2) || (ph == 3);
            m_quiet = (ph == 2);
            // phase 3: sender floods while the result side stalls for a while
            if (ph == 3)
                long_hold = 1'b1;
            phase_start = chars_sent;
            while (chars_sent - phase_start < PHASE_CHARS) begin
                build_random_code();
                send_code();
            end
        end

        drain();
        if (fail_count == 0 && pending_results == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
